// ===== rtl/core/rlc_pkg.sv =====
// Shared types, constants and the byte-wide CRC step for the route label core.
package rlc_pkg;

  localparam int unsigned LABEL_W   = 160;
  localparam int unsigned CRC_W     = 16;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned MSG_BYTES = 18;

  typedef logic [CRC_W-1:0]   crc_t;
  typedef logic [LABEL_W-1:0] label_t;
  typedef logic [BYTE_W-1:0]  byte_t;

  localparam crc_t CRC_INIT   = 16'h0000;
  localparam crc_t POLY_RESET = 16'h8005;

  function automatic crc_t crc_byte(crc_t crc_in, byte_t data, crc_t poly);
    crc_t c;
    logic fb;
    c = crc_in;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      fb = c[CRC_W-1] ^ data[i];
      c  = {c[CRC_W-2:0], 1'b0};
      if (fb) begin
        c = c ^ poly;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/rlc_stage.sv =====
// One pipeline stage: fold the leading label byte into the CRC and shift the label.
module rlc_stage
  import rlc_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   valid_in,
  input  crc_t   crc_in,
  input  label_t msg_in,
  input  crc_t   poly,
  output logic   valid_out,
  output crc_t   crc_out,
  output label_t msg_out
);

  logic   valid_r;
  crc_t   crc_r;
  crc_t   crc_nxt;
  label_t msg_r;
  label_t msg_nxt;

  assign crc_nxt = crc_byte(crc_in, msg_in[LABEL_W-1 -: BYTE_W], poly);
  assign msg_nxt = {msg_in[LABEL_W-BYTE_W-1:0], {BYTE_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
    msg_r <= msg_nxt;
  end

  assign valid_out = valid_r;
  assign crc_out   = crc_r;
  assign msg_out   = msg_r;

endmodule

// ===== rtl/core/route_label_crc16_next_hop_core.sv =====
// Top level: 18-stage CRC-16 pipeline that turns a route label into a next-hop port.
//
// One label is taken on every cycle that start is high; busy never rises. Each label
// passes 17 byte stages and an output register, one label byte folded into the CRC per
// stage, and its port number appears on out_next_port with out_valid from the output
// register. The receiver cannot stall; results are never held back. cfg_ready is
// high only while the pipeline holds no label and start is low, so the polynomial
// changes between items.
module route_label_crc16_next_hop_core
  import rlc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_route_top,
  input  logic [63:0] in_route_middle,
  input  logic [63:0] in_route_bottom,
  output logic        out_valid,
  output logic [15:0] out_next_port,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int unsigned NSTG = MSG_BYTES - 1;

  logic   valid_s [0:NSTG];
  crc_t   crc_s   [0:NSTG];
  label_t msg_s   [0:NSTG];
  logic [NSTG:0] valid_vec;

  crc_t poly_r;
  logic out_valid_r;
  crc_t out_port_r;
  crc_t out_port_nxt;

  assign busy = 1'b0;

  assign valid_s[0] = start;
  assign crc_s[0]   = CRC_INIT;
  assign msg_s[0]   = {in_route_top, in_route_middle, in_route_bottom};

  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    rlc_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .valid_in  (valid_s[k]),
      .crc_in    (crc_s[k]),
      .msg_in    (msg_s[k]),
      .poly      (poly_r),
      .valid_out (valid_s[k+1]),
      .crc_out   (crc_s[k+1]),
      .msg_out   (msg_s[k+1])
    );
  end

  for (genvar k = 1; k <= NSTG; k++) begin : g_vld
    assign valid_vec[k] = valid_s[k];
  end
  assign valid_vec[0] = out_valid_r;

  assign cfg_ready = ~start & ~|valid_vec;

  assign out_port_nxt = crc_byte(crc_s[NSTG], msg_s[NSTG][LABEL_W-1 -: BYTE_W], poly_r)
                        ^ msg_s[NSTG][LABEL_W-BYTE_W-1 -: CRC_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r      <= POLY_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= valid_s[NSTG];
      if (cfg_valid && cfg_ready) begin
        poly_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_port_r <= out_port_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_next_port = out_port_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##18 out_valid)
    else $error("item did not leave after 18 cycles");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 18))
    else $error("result without an item");

  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |=> !out_valid)
    else $error("result right after a config write");

  a_item_blocks_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> !cfg_ready)
    else $error("config open with item in flight");

endmodule

// ===== tb/route_label_crc16_next_hop_core_tb.sv =====
// Testbench for the route label CRC-16 next-hop core: directed and random labels checked against a bitwise predictor.
module route_label_crc16_next_hop_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rlc_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_route_top;
  logic [63:0] in_route_middle;
  logic [63:0] in_route_bottom;
  logic        out_valid;
  logic [15:0] out_next_port;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  crc_t        expected_ports[$];
  crc_t        node_poly_model;
  crc_t        want_port;
  int unsigned labels_taken;
  int unsigned poly_writes;
  int unsigned mismatches;
  bit          no_gaps;

  route_label_crc16_next_hop_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_route_top    (in_route_top),
    .in_route_middle (in_route_middle),
    .in_route_bottom (in_route_bottom),
    .out_valid       (out_valid),
    .out_next_port   (out_next_port),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic crc_t crc_next_port(logic [31:0] top, logic [63:0] mid,
                                         logic [63:0] bot, crc_t poly);
    label_t label;
    crc_t   rem;
    logic   fb;
    label = {top, mid, bot};
    rem   = CRC_INIT;
    for (int i = LABEL_W - 1; i >= CRC_W; i--) begin
      fb  = rem[CRC_W-1] ^ label[i];
      rem = {rem[CRC_W-2:0], 1'b0};
      if (fb) begin
        rem = rem ^ poly;
      end
    end
    return rem ^ label[CRC_W-1:0];
  endfunction

  function automatic logic [63:0] pick_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic report_mismatch(string what, crc_t want, crc_t got);
    $display("%0t: mismatch on %s, expected %h got %h", $time, what, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        expected_ports.push_back(crc_next_port(in_route_top, in_route_middle,
                                               in_route_bottom, node_poly_model));
        labels_taken++;
      end
      if (cfg_valid && cfg_ready) begin
        node_poly_model = cfg_data;
        poly_writes++;
      end
      if (out_valid) begin
        if (expected_ports.size() == 0) begin
          report_mismatch("unexpected result", '0, out_next_port);
        end else begin
          want_port = expected_ports.pop_front();
          if (out_next_port !== want_port) begin
            report_mismatch("next_port", want_port, out_next_port);
          end
        end
      end
    end
  end

  // Call at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_label(logic [31:0] top, logic [63:0] mid, logic [63:0] bot);
    int unsigned taken_before;
    while (!no_gaps && $urandom_range(99) < 28) begin
      start           <= 1'b0;
      in_route_top    <= $urandom;
      in_route_middle <= {$urandom, $urandom};
      in_route_bottom <= {$urandom, $urandom};
      @(negedge clk);
    end
    taken_before     = labels_taken;
    start           <= 1'b1;
    in_route_top    <= top;
    in_route_middle <= mid;
    in_route_bottom <= bot;
    do @(negedge clk); while (labels_taken == taken_before);
  endtask

  task automatic drain_labels();
    start <= 1'b0;
    while (expected_ports.size() != 0) @(negedge clk);
  endtask

  task automatic write_node_poly(crc_t poly);
    int unsigned writes_before;
    drain_labels();
    repeat ($urandom_range(0, 3)) @(negedge clk);
    writes_before = poly_writes;
    cfg_valid    <= 1'b1;
    cfg_data     <= poly;
    do @(negedge clk); while (poly_writes == writes_before);
    cfg_valid    <= 1'b0;
    cfg_data     <= crc_t'($urandom);
  endtask

  task automatic test_reset_poly_extremes();
    send_label('0, '0, '0);
    send_label('1, '1, '1);
    send_label('0, '0, 64'h0000_0000_0000_FFFF);
    send_label('0, '0, 64'h0000_0000_0001_0000);
    send_label(32'h8000_0000, '0, '0);
    send_label(32'hAAAA_AAAA, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    send_label(32'h0000_0001, 64'h8000_0000_0000_0000, '0);
    send_label('0, 64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000);
  endtask

  // With no polynomial the remainder stays zero, so the port is just label bits 15..0.
  task automatic test_zero_poly();
    write_node_poly('0);
    send_label('0, '0, 64'h0000_0000_1234_0000);
    send_label('1, '1, 64'hFFFF_FFFF_ABCD_0F0F);
    send_label($urandom, {$urandom, $urandom}, {$urandom, $urandom});
    send_label($urandom, {$urandom, $urandom}, {$urandom, $urandom});
  endtask

  task automatic test_poly_extremes();
    crc_t polys[3];
    polys = '{16'hFFFF, 16'h0001, 16'h8000};
    foreach (polys[p]) begin
      write_node_poly(polys[p]);
      send_label('1, '1, '1);
      send_label(32'h8000_0000, '0, '0);
      send_label($urandom, {$urandom, $urandom}, {$urandom, $urandom});
    end
  endtask

  task automatic test_random_labels();
    crc_t polys[10];
    polys = '{16'h0000, 16'h8005, 16'h0000, 16'h1021, 16'h0000,
              16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000};
    for (int phase = 0; phase < 10; phase++) begin
      if (polys[phase] == 16'h0000 && phase != 5) begin
        polys[phase] = crc_t'($urandom);
      end
      write_node_poly(polys[phase]);
      no_gaps = (phase == 4);
      for (int n = 0; n < 125; n++) begin
        send_label(pick_word(), pick_word(), pick_word());
      end
      no_gaps = 1'b0;
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_route_top    = '0;
    in_route_middle = '0;
    in_route_bottom = '0;
    cfg_valid       = 1'b0;
    cfg_data        = '0;
    node_poly_model = POLY_RESET;
    labels_taken    = 0;
    poly_writes     = 0;
    mismatches      = 0;
    no_gaps         = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_poly_extremes();
    test_zero_poly();
    test_poly_extremes();
    test_random_labels();

    drain_labels();
    repeat (30) @(negedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
